// ----- rtl/harmonic_matrix_row_generator_macros.svh -----
// assertion macros shared by the rtl
`ifndef HARMONIC_MATRIX_ROW_GENERATOR_MACROS_SVH
`define HARMONIC_MATRIX_ROW_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HMRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HMRG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hmrg_pkg.sv -----
`default_nettype none

package hmrg_pkg;

    localparam int SIZE_BITS      = 17;
    localparam int GAIN_BITS      = 24;
    localparam int VAL_BITS       = 48;
    localparam int MAG_BITS       = 64;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;
    // root digits resolved per sqrt pipeline stage
    localparam int SQRT_DPS       = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATRIX_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUPLING_GAIN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_SPACING = 2'd2;

    localparam logic [MAG_BITS-1:0] MAX_POS_MAG = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [MAG_BITS-1:0] MAX_NEG_MAG = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic has_left;
        logic has_right;
    } t_row_flags;

    typedef struct packed {
        logic                neg;
        logic [GAIN_BITS-1:0] mag;
    } t_sign_mag;

    typedef struct packed {
        logic [VAL_BITS-1:0] value;
        logic                sat;
    } t_sat_val;

    typedef struct packed {
        t_sat_val left;
        t_sat_val diag;
        t_sat_val right;
    } t_row_vals;

    typedef enum logic [1:0] {
        SER_IDLE,
        SER_LEFT,
        SER_DIAG,
        SER_RIGHT
    } t_ser_state;

    function automatic t_sign_mag split_sign(input logic [GAIN_BITS-1:0] raw);
        t_sign_mag r;
        r.neg = raw[GAIN_BITS-1];
        r.mag = r.neg ? (~raw + {{(GAIN_BITS-1){1'b0}}, 1'b1}) : raw;
        return r;
    endfunction

    function automatic t_sat_val sat_apply(input logic [MAG_BITS-1:0] mag, input logic neg);
        t_sat_val r;
        logic [MAG_BITS-1:0] m;
        m     = mag;
        r.sat = 1'b0;
        if (neg) begin
            if (m > MAX_NEG_MAG) begin
                m     = MAX_NEG_MAG;
                r.sat = 1'b1;
            end
            m = ~m + {{(MAG_BITS-1){1'b0}}, 1'b1};
        end else if (m > MAX_POS_MAG) begin
            m     = MAX_POS_MAG;
            r.sat = 1'b1;
        end
        r.value = m[VAL_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hmrg_sqrt_pipe.sv -----
`default_nettype none

module hmrg_sqrt_pipe import hmrg_pkg::*; #(
    parameter int NB = 18,
    parameter int ND = 25,
    parameter int SW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NB-1:0] i_n_a,
    input  wire logic [NB-1:0] i_n_b,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [ND-1:0]      o_root_a,
    output logic [ND-1:0]      o_root_b,
    output logic [SW-1:0]      o_side
);

    localparam int NS = (ND + SQRT_DPS - 1) / SQRT_DPS;
    localparam int RW = ND + 2;

    logic          r_valid [NS];
    logic [SW-1:0] r_side  [NS];
    logic [RW-1:0] r_rem   [2][NS];
    logic [ND-1:0] r_root  [2][NS];
    logic [NB-1:0] r_rad   [2][NS];
    logic [NB-1:0] in_n    [2];

    assign in_n[0] = i_n_a;
    assign in_n[1] = i_n_b;

    genvar s, l;
    for (s = 0; s < NS; s++) begin : g_stage
        logic          p_valid;
        logic [SW-1:0] p_side;

        if (s == 0) begin : g_head
            assign p_valid = i_valid;
            assign p_side  = i_side;
        end else begin : g_body
            assign p_valid = r_valid[s-1];
            assign p_side  = r_side[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= p_side;
            end
        end

        for (l = 0; l < 2; l++) begin : g_lane
            logic [RW-1:0] p_rem;
            logic [ND-1:0] p_root;
            logic [NB-1:0] p_rad;
            logic [RW-1:0] n_rem;
            logic [ND-1:0] n_root;
            logic [NB-1:0] n_rad;

            if (s == 0) begin : g_head
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rad  = in_n[l];
            end else begin : g_body
                assign p_rem  = r_rem[l][s-1];
                assign p_root = r_root[l][s-1];
                assign p_rad  = r_rad[l][s-1];
            end

            // restoring square root, one radicand bit pair per digit
            always_comb begin
                logic [RW-1:0] trial;
                n_rem  = p_rem;
                n_root = p_root;
                n_rad  = p_rad;
                trial  = '0;
                for (int j = 0; j < SQRT_DPS; j++) begin
                    if (s * SQRT_DPS + j < ND) begin
                        n_rem = {n_rem[RW-3:0], n_rad[NB-1 -: 2]};
                        n_rad = n_rad << 2;
                        trial = {n_root, 2'b01};
                        if (n_rem >= trial) begin
                            n_rem  = n_rem - trial;
                            n_root = {n_root[ND-2:0], 1'b1};
                        end else begin
                            n_root = {n_root[ND-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][s]  <= n_rem;
                    r_root[l][s] <= n_root;
                    r_rad[l][s]  <= n_rad;
                end
            end
        end
    end

    assign o_valid  = r_valid[NS-1];
    assign o_side   = r_side[NS-1];
    assign o_root_a = r_root[0][NS-1];
    assign o_root_b = r_root[1][NS-1];

endmodule

`default_nettype wire

// ----- rtl/hmrg_arith.sv -----
`default_nettype none

module hmrg_arith import hmrg_pkg::*; #(
    parameter int INDEX_BITS = 16,
    parameter int FRAC_BITS  = 16,
    parameter int ND         = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [INDEX_BITS-1:0] i_row,
    input  wire t_row_flags            i_flags,
    input  wire logic [ND-1:0]         i_root_a,
    input  wire logic [ND-1:0]         i_root_b,
    input  wire logic [GAIN_BITS-1:0]  i_coupling,
    input  wire logic [GAIN_BITS-1:0]  i_spacing,
    output logic                       o_valid,
    output logic [INDEX_BITS-1:0]      o_row,
    output t_row_flags                 o_flags,
    output t_row_vals                  o_vals
);

    localparam int LO  = ND / 2;
    localparam int HI  = ND - LO;
    localparam int PLW = GAIN_BITS + LO;
    localparam int PHW = GAIN_BITS + HI;
    localparam int PW  = GAIN_BITS + ND;
    localparam int MW  = PW - FRAC_BITS;
    localparam int DW  = GAIN_BITS + INDEX_BITS;

    t_sign_mag lam;
    t_sign_mag omg;

    assign lam = split_sign(i_coupling);
    assign omg = split_sign(i_spacing);

    // stage 1: partial products
    logic                  r1_valid;
    logic [INDEX_BITS-1:0] r1_row;
    t_row_flags            r1_flags;
    logic [PLW-1:0]        r1_pa_lo, r1_pb_lo;
    logic [PHW-1:0]        r1_pa_hi, r1_pb_hi;
    logic [DW-1:0]         r1_diag;

    // stage 2: product sums, truncated
    logic                  r2_valid;
    logic [INDEX_BITS-1:0] r2_row;
    t_row_flags            r2_flags;
    logic [MW-1:0]         r2_mag_a, r2_mag_b;
    logic [DW-1:0]         r2_diag;
    logic [PW-1:0]         n_sum_a, n_sum_b;

    // stage 3: sign and saturation
    logic                  r3_valid;
    logic [INDEX_BITS-1:0] r3_row;
    t_row_flags            r3_flags;
    t_row_vals             r3_vals;

    assign n_sum_a = PW'(r1_pa_lo) + (PW'(r1_pa_hi) << LO);
    assign n_sum_b = PW'(r1_pb_lo) + (PW'(r1_pb_hi) << LO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_row   <= i_row;
            r1_flags <= i_flags;
            r1_pa_lo <= PLW'(lam.mag) * PLW'(i_root_a[LO-1:0]);
            r1_pa_hi <= PHW'(lam.mag) * PHW'(i_root_a[ND-1:LO]);
            r1_pb_lo <= PLW'(lam.mag) * PLW'(i_root_b[LO-1:0]);
            r1_pb_hi <= PHW'(lam.mag) * PHW'(i_root_b[ND-1:LO]);
            r1_diag  <= DW'(omg.mag) * DW'(i_row);

            r2_row   <= r1_row;
            r2_flags <= r1_flags;
            r2_mag_a <= n_sum_a[PW-1:FRAC_BITS];
            r2_mag_b <= n_sum_b[PW-1:FRAC_BITS];
            r2_diag  <= r1_diag;

            r3_row        <= r2_row;
            r3_flags      <= r2_flags;
            r3_vals.left  <= sat_apply(MAG_BITS'(r2_mag_a), lam.neg);
            r3_vals.right <= sat_apply(MAG_BITS'(r2_mag_b), lam.neg);
            r3_vals.diag  <= sat_apply(MAG_BITS'(r2_diag), omg.neg);
        end
    end

    assign o_valid = r3_valid;
    assign o_row   = r3_row;
    assign o_flags = r3_flags;
    assign o_vals  = r3_vals;

endmodule

`default_nettype wire

// ----- rtl/hmrg_serializer.sv -----
`default_nettype none

module hmrg_serializer import hmrg_pkg::*; #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [INDEX_BITS-1:0] i_row,
    input  wire t_row_flags            i_flags,
    input  wire t_row_vals             i_vals,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [INDEX_BITS-1:0]      o_column_index,
    output logic [VAL_BITS-1:0]        o_entry_value,
    output logic                       o_last_entry,
    output logic                       o_value_saturated
);

    t_ser_state            r_state, n_state;
    logic [INDEX_BITS-1:0] r_row;
    t_row_flags            r_flags;
    t_row_vals             r_vals;
    logic                  fire;
    logic                  load;
    t_sat_val              cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SER_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row   <= i_row;
            r_flags <= i_flags;
            r_vals  <= i_vals;
        end
    end

    always_comb begin
        o_valid        = 1'b1;
        o_last_entry   = 1'b0;
        o_column_index = r_row;
        cur            = r_vals.diag;
        n_state        = r_state;
        unique case (r_state)
            SER_IDLE: begin
                o_valid = 1'b0;
            end
            SER_LEFT: begin
                o_column_index = r_row - INDEX_BITS'(1);
                cur            = r_vals.left;
            end
            SER_DIAG: begin
                o_last_entry = !r_flags.has_right;
            end
            SER_RIGHT: begin
                o_column_index = r_row + INDEX_BITS'(1);
                cur            = r_vals.right;
                o_last_entry   = 1'b1;
            end
        endcase

        fire    = o_valid && i_ready;
        // a new row may follow in the cycle the last beat of this one leaves
        o_ready = !o_valid || (fire && o_last_entry);
        load    = i_valid && o_ready;

        if (fire) begin
            unique case (r_state)
                SER_LEFT:  n_state = SER_DIAG;
                SER_DIAG:  n_state = r_flags.has_right ? SER_RIGHT : SER_IDLE;
                SER_RIGHT: n_state = SER_IDLE;
                SER_IDLE:  n_state = SER_IDLE;
            endcase
        end
        if (load) begin
            n_state = i_flags.has_left ? SER_LEFT : SER_DIAG;
        end

        o_entry_value     = cur.value;
        o_value_saturated = cur.sat;
    end

endmodule

`default_nettype wire

// ----- rtl/harmonic_matrix_row_generator.sv -----
// harmonic_matrix_row_generator
// row request channel: i_valid / o_ready with i_row_index. each accepted row
// i below the matrix size yields its nonzero entries in column order on the
// result channel o_valid / i_ready: lambda*sqrt(i) at i-1 (not on row 0),
// omega*i at i, lambda*sqrt(i+1) at i+1 (not on the last row); o_last_entry
// marks the final beat of a row. rows at or past the size give no beats.
// config channel: i_cfg_valid / o_cfg_ready (always ready) writes register
// i_cfg_index (0 size, 1 lambda, 2 omega); write only while the block is idle.
// the square root pipeline has NS = ceil(((INDEX_BITS+2)/2 + FRAC_BITS)/4)
// stages; it and the three multiply, sum and saturate stages advance on one
// enable, while the output serializer steps on its own handshake.
// throughput: while o_ready is high a new row may enter every cycle, also an
// out-of-range one; the result channel moves one beat per cycle while i_ready
// is high, three beats for a full row and two for an edge row.
// a stalled receiver holds the current beat; the pipeline then freezes once a
// finished row waits at its end, and o_ready drops. reset empties every stage
// and sets size 2, lambda 0 and omega 0.
`default_nettype none

module harmonic_matrix_row_generator import hmrg_pkg::*; #(
    parameter int INDEX_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [INDEX_BITS-1:0]     i_row_index,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [INDEX_BITS-1:0]          o_column_index,
    output logic [VAL_BITS-1:0]            o_entry_value,
    output logic                           o_last_entry,
    output logic                           o_value_saturated
);

    `include "harmonic_matrix_row_generator_macros.svh"

    localparam int NB = 2 * ((INDEX_BITS + 2) / 2);
    localparam int ND = NB / 2 + FRAC_BITS;
    localparam int SW = INDEX_BITS + 2;
    localparam int CW = (INDEX_BITS + 1 > SIZE_BITS) ? INDEX_BITS + 1 : SIZE_BITS;

    logic [SIZE_BITS-1:0] r_matrix_size;
    logic [GAIN_BITS-1:0] r_coupling_gain;
    logic [GAIN_BITS-1:0] r_level_spacing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size   <= SIZE_BITS'(2);
            r_coupling_gain <= '0;
            r_level_spacing <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MATRIX_SIZE:   r_matrix_size   <= i_cfg_data[SIZE_BITS-1:0];
                CFG_COUPLING_GAIN: r_coupling_gain <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LEVEL_SPACING: r_level_spacing <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // entry checks against the size, clamped to the index range
    logic [CW-1:0] size_ext, size_lim, size_eff, row_ext;
    logic          in_range;
    t_row_flags    in_flags;

    assign size_ext = CW'(r_matrix_size);
    assign size_lim = CW'(1) << INDEX_BITS;
    assign size_eff = (size_ext > size_lim) ? size_lim : size_ext;
    assign row_ext  = CW'(i_row_index);
    assign in_range = row_ext < size_eff;
    assign in_flags.has_left  = i_row_index != '0;
    assign in_flags.has_right = (row_ext + CW'(1)) < size_eff;

    logic                  pipe_en;
    logic                  sq_valid;
    logic [SW-1:0]         sq_side;
    logic [ND-1:0]         sq_root_a, sq_root_b;
    logic [INDEX_BITS-1:0] sq_row;
    t_row_flags            sq_flags;
    logic                  ar_valid;
    logic [INDEX_BITS-1:0] ar_row;
    t_row_flags            ar_flags;
    t_row_vals             ar_vals;
    logic                  ser_ready;

    assign pipe_en = !ar_valid || ser_ready;
    assign o_ready = pipe_en;

    hmrg_sqrt_pipe #(
        .NB(NB),
        .ND(ND),
        .SW(SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid && in_range),
        .i_n_a   (NB'(i_row_index)),
        .i_n_b   (NB'(i_row_index) + NB'(1)),
        .i_side  ({in_flags, i_row_index}),
        .o_valid (sq_valid),
        .o_root_a(sq_root_a),
        .o_root_b(sq_root_b),
        .o_side  (sq_side)
    );

    assign {sq_flags, sq_row} = sq_side;

    hmrg_arith #(
        .INDEX_BITS(INDEX_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ND        (ND)
    ) u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (sq_valid),
        .i_row     (sq_row),
        .i_flags   (sq_flags),
        .i_root_a  (sq_root_a),
        .i_root_b  (sq_root_b),
        .i_coupling(r_coupling_gain),
        .i_spacing (r_level_spacing),
        .o_valid   (ar_valid),
        .o_row     (ar_row),
        .o_flags   (ar_flags),
        .o_vals    (ar_vals)
    );

    hmrg_serializer #(
        .INDEX_BITS(INDEX_BITS)
    ) u_ser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (ar_valid),
        .o_ready          (ser_ready),
        .i_row            (ar_row),
        .i_flags          (ar_flags),
        .i_vals           (ar_vals),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_column_index   (o_column_index),
        .o_entry_value    (o_entry_value),
        .o_last_entry     (o_last_entry),
        .o_value_saturated(o_value_saturated)
    );

    // beats of one row leave back to back, in rising column order
    `HMRG_ASSERT_NXT(a_row_contiguous, i_clk, i_rst_n, o_valid && i_ready && !o_last_entry, o_valid, "row beats interrupted")
    `HMRG_ASSERT_NXT(a_column_order, i_clk, i_rst_n, o_valid && i_ready && !o_last_entry, o_column_index == $past(o_column_index) + INDEX_BITS'(1), "column order broken")
    // the pipeline only stalls behind a finished row
    `HMRG_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_ready, ar_valid && o_valid, "stall without waiting row")

endmodule

`default_nettype wire
